[hw/rtl/abe_pkg.sv]
// abe_pkg: types and constants shared by the ASCII expression evaluator.
// No dependencies.
package abe_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CHAR_W-1:0] C_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] C_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] C_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] C_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] C_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] C_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] C_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] C_NINE  = 8'h39;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADOP   = 2'd2;

  typedef enum logic [1:0] {
    S_PARSE = 2'b01,
    S_CALC  = 2'b10
  } state_t;

  typedef enum logic [5:0] {
    P_LEAD   = 6'b000001,
    P_FIRST  = 6'b000010,
    P_PREOP  = 6'b000100,
    P_POSTOP = 6'b001000,
    P_SECOND = 6'b010000,
    P_TAIL   = 6'b100000
  } phase_t;

  typedef enum logic [4:0] {
    K_ADD = 5'b00001,
    K_SUB = 5'b00010,
    K_MUL = 5'b00100,
    K_DIV = 5'b01000,
    K_BAD = 5'b10000
  } kind_t;

endpackage

[hw/rtl/abe_if.sv]
// abe_if: valid/ready channel interfaces for expression bytes and results.
// Depends on abe_pkg.
interface abe_char_if
  import abe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface abe_res_if
  import abe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic [STAT_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

[hw/rtl/ascii_binary_expression_evaluator.sv]
// Streaming two-operand decimal calculator: ASCII bytes in, one result per terminator.
// Depends on abe_pkg and the abe_char_if / abe_res_if channel interfaces.
// Throughput: one non-terminator byte per cycle while parsing (ready drops during compute).
// Terminator: accepted, then the compute state finishes add, sub and errors directly, or
//   steps multiply or divide through all 32 bits (one bit per cycle on the shared 33-bit adder).
// The result sits in an output register; bytes of the next expression flow meanwhile.
// Reset (rst_n low, synchronous) clears the parser, operands and result valid.
module ascii_binary_expression_evaluator
  import abe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  abe_char_if.sink     in_ch,
  abe_res_if.source    out_ch
);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  kind_t             kind_r, kind_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [CHAR_W-1:0] op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [DATA_W:0]   opx, opy;
  logic              sub;
  logic [DATA_W+1:0] sum;
  logic [DATA_W-1:0] digit;
  logic [DATA_W-1:0] a_acc, b_acc;
  logic [CHAR_W-1:0] c;
  logic              is_sp, is_dg, in_fire;
  logic              done;
  logic [DATA_W-1:0] done_val;
  logic [STAT_W-1:0] done_st;

  assign c       = in_ch.char_in;
  assign is_sp   = (c == C_SPACE);
  assign is_dg   = (c >= C_ZERO) && (c <= C_NINE);
  assign in_ch.ready = (state_r == S_PARSE) && !(out_valid_r && (c == C_NUL));
  assign in_fire = in_ch.valid && in_ch.ready;

  assign digit = {{(DATA_W-4){1'b0}}, c[3:0]};
  assign a_acc = {a_r[DATA_W-4:0], 3'b000} + {a_r[DATA_W-2:0], 1'b0} + digit;
  assign b_acc = {b_r[DATA_W-4:0], 3'b000} + {b_r[DATA_W-2:0], 1'b0} + digit;

  // shared adder: add/sub result, one partial-product step, one restoring-divide step
  always_comb begin
    sub = 1'b0;
    opx = {1'b0, a_r};
    opy = {1'b0, b_r};
    case (kind_r)
      K_SUB: sub = 1'b1;
      K_MUL: begin
        opx = {1'b0, acc_r};
        opy = b_r[0] ? {1'b0, a_r} : '0;
      end
      K_DIV: begin
        opx = {acc_r, a_r[DATA_W-1]};
        opy = {1'b0, b_r};
        sub = 1'b1;
      end
      default: ;
    endcase
    sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + {{(DATA_W+1){1'b0}}, sub};
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    done          = 1'b0;
    done_val      = '0;
    done_st       = ST_OK;

    case (state_r)
      S_PARSE: begin
        if (in_fire) begin
          if (c == C_NUL) begin
            case (op_r)
              C_PLUS:  kind_nxt = K_ADD;
              C_MINUS: kind_nxt = K_SUB;
              C_STAR:  kind_nxt = K_MUL;
              C_SLASH: kind_nxt = K_DIV;
              default: kind_nxt = K_BAD;
            endcase
            cnt_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = S_CALC;
          end else begin
            case (phase_r)
              P_LEAD: begin
                if (is_dg) begin
                  a_nxt     = a_acc;
                  phase_nxt = P_FIRST;
                end else if (!is_sp) begin
                  op_nxt    = c;
                  phase_nxt = P_POSTOP;
                end
              end
              P_FIRST: begin
                if (is_dg) begin
                  a_nxt = a_acc;
                end else if (is_sp) begin
                  phase_nxt = P_PREOP;
                end else begin
                  op_nxt    = c;
                  phase_nxt = P_POSTOP;
                end
              end
              P_PREOP: begin
                if (!is_sp) begin
                  op_nxt    = c;
                  phase_nxt = P_POSTOP;
                end
              end
              P_POSTOP: begin
                if (is_dg) begin
                  b_nxt     = b_acc;
                  phase_nxt = P_SECOND;
                end else if (!is_sp) begin
                  phase_nxt = P_TAIL;
                end
              end
              P_SECOND: begin
                if (is_dg) begin
                  b_nxt = b_acc;
                end else begin
                  phase_nxt = P_TAIL;
                end
              end
              default: phase_nxt = P_TAIL;
            endcase
          end
        end
      end
      S_CALC: begin
        case (kind_r)
          K_ADD, K_SUB: begin
            done     = 1'b1;
            done_val = sum[DATA_W-1:0];
          end
          K_MUL: begin
            acc_nxt = sum[DATA_W-1:0];
            a_nxt   = {a_r[DATA_W-2:0], 1'b0};
            b_nxt   = {1'b0, b_r[DATA_W-1:1]};
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == '1) begin
              done     = 1'b1;
              done_val = sum[DATA_W-1:0];
            end
          end
          K_DIV: begin
            if (b_r == '0) begin
              done    = 1'b1;
              done_st = ST_DIVZERO;
            end else begin
              acc_nxt = sum[DATA_W+1] ? sum[DATA_W-1:0] : opx[DATA_W-1:0];
              a_nxt   = {a_r[DATA_W-2:0], sum[DATA_W+1]};
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == '1) begin
                done     = 1'b1;
                done_val = {a_r[DATA_W-2:0], sum[DATA_W+1]};
              end
            end
          end
          default: begin
            done    = 1'b1;
            done_st = ST_BADOP;
          end
        endcase
      end
      default: state_nxt = S_PARSE;
    endcase

    if (done) begin
      value_nxt     = done_val;
      status_nxt    = done_st;
      out_valid_nxt = 1'b1;
      a_nxt         = '0;
      b_nxt         = '0;
      op_nxt        = C_NUL;
      phase_nxt     = P_LEAD;
      state_nxt     = S_PARSE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PARSE;
      phase_r     <= P_LEAD;
      kind_r      <= K_BAD;
      a_r         <= '0;
      b_r         <= '0;
      op_r        <= C_NUL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = value_r;
  assign out_ch.status = status_r;

endmodule

[hw/rtl/abe_checker.sv]
// abe_checker: port-level assertions for the expression evaluator, plus its bind.
// Depends on abe_pkg and ascii_binary_expression_evaluator.
module abe_checker
  import abe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CHAR_W-1:0] in_char,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value,
  input logic [STAT_W-1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_value == '0))
    else $error("error result with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_DIVZERO) ||
                  (out_status == ST_BADOP))
    else $error("undefined status code");

  a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_char == C_NUL) |=> !in_ready)
    else $error("byte taken in the cycle after a terminator");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ascii_binary_expression_evaluator abe_checker u_abe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_char    (in_ch.char_in),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for ascii_binary_expression_evaluator: directed table plus random expressions, each
// result checked against an in-bench byte-level calculator or a pinned table value. Depends on
// abe_pkg, abe_char_if / abe_res_if and the evaluator RTL.
module testbench;
  import abe_pkg::*;

  localparam int N_BYTES     = 1000;
  localparam int QUIET_FROM  = 850;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
  } calc_res_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              pinned;
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
  } dir_row_t;

  logic clk;
  logic rst_n;

  abe_char_if char_ch ();
  abe_res_if  res_ch ();

  ascii_binary_expression_evaluator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_ch),
    .out_ch (res_ch)
  );

  // calculator state
  phase_t            parse_ph = P_LEAD;
  logic [DATA_W-1:0] lhs_acc  = '0;
  logic [DATA_W-1:0] rhs_acc  = '0;
  logic [CHAR_W-1:0] op_byte  = C_NUL;

  calc_res_t pending_results[$];

  int  errors        = 0;
  int  bytes_sent    = 0;
  int  results_seen  = 0;
  int  divzero_seen  = 0;
  int  badop_seen    = 0;
  int  cycle_cnt     = 0;
  bit  gaps_on       = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  hold_done     = 1'b0;
  bit  pause_done    = 1'b0;

  dir_row_t dir_tab [29] = '{
    '{C_NUL,          1'b1, 32'd0,          ST_BADOP},
    '{C_SPACE,        1'b0, 32'd0,          ST_OK},
    '{8'hFF,          1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b1, 32'd0,          ST_BADOP},
    '{C_ZERO + 8'd9,  1'b0, 32'd0,          ST_OK},
    '{C_SLASH,        1'b0, 32'd0,          ST_OK},
    '{C_ZERO,         1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b1, 32'd0,          ST_DIVZERO},
    '{C_ZERO + 8'd8,  1'b0, 32'd0,          ST_OK},
    '{C_MINUS,        1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd9,  1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b1, 32'hFFFF_FFFF,  ST_OK},
    '{C_ZERO + 8'd7,  1'b0, 32'd0,          ST_OK},
    '{C_SLASH,        1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd2,  1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd6,  1'b0, 32'd0,          ST_OK},
    '{C_STAR,         1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd7,  1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b0, 32'd0,          ST_OK},
    '{C_PLUS,         1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd2,  1'b0, 32'd0,          ST_OK},
    '{C_SPACE,        1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd9,  1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd5,  1'b0, 32'd0,          ST_OK},
    '{C_SPACE,        1'b0, 32'd0,          ST_OK},
    '{C_ZERO + 8'd3,  1'b0, 32'd0,          ST_OK},
    '{C_NUL,          1'b1, 32'd0,          ST_BADOP}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Advances the calculator by one byte; returns 1 when the byte yields a result.
  function automatic bit eval_byte(input logic [CHAR_W-1:0] c, output calc_res_t res);
    logic is_dig;
    logic is_sp;
    is_dig = (c >= C_ZERO) && (c <= C_NINE);
    is_sp  = (c == C_SPACE);
    res    = '0;
    if (c == C_NUL) begin
      res.status = ST_OK;
      case (op_byte)
        C_PLUS:  res.value = lhs_acc + rhs_acc;
        C_MINUS: res.value = lhs_acc - rhs_acc;
        C_STAR:  res.value = lhs_acc * rhs_acc;
        C_SLASH: begin
          if (rhs_acc != '0) res.value = lhs_acc / rhs_acc;
          else res.status = ST_DIVZERO;
        end
        default: res.status = ST_BADOP;
      endcase
      parse_ph = P_LEAD;
      lhs_acc  = '0;
      rhs_acc  = '0;
      op_byte  = C_NUL;
      return 1'b1;
    end
    case (parse_ph)
      P_LEAD: begin
        if (is_dig) begin
          lhs_acc  = lhs_acc * 10 + (c - C_ZERO);
          parse_ph = P_FIRST;
        end else if (!is_sp) begin
          op_byte  = c;
          parse_ph = P_POSTOP;
        end
      end
      P_FIRST: begin
        if (is_dig) begin
          lhs_acc = lhs_acc * 10 + (c - C_ZERO);
        end else if (is_sp) begin
          parse_ph = P_PREOP;
        end else begin
          op_byte  = c;
          parse_ph = P_POSTOP;
        end
      end
      P_PREOP: begin
        if (!is_sp) begin
          op_byte  = c;
          parse_ph = P_POSTOP;
        end
      end
      P_POSTOP: begin
        if (is_dig) begin
          rhs_acc  = rhs_acc * 10 + (c - C_ZERO);
          parse_ph = P_SECOND;
        end else if (!is_sp) begin
          parse_ph = P_TAIL;
        end
      end
      P_SECOND: begin
        if (is_dig) rhs_acc = rhs_acc * 10 + (c - C_ZERO);
        else parse_ph = P_TAIL;
      end
      default: parse_ph = P_TAIL;
    endcase
    return 1'b0;
  endfunction

  // Offers one byte at the falling edge and returns after the beat is taken.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input bit pinned = 1'b0,
                           input calc_res_t pinned_res = '0);
    calc_res_t res;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      char_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    char_ch.valid   = 1'b1;
    char_ch.char_in = c;
    do @(posedge clk); while (!char_ch.ready);
    bytes_sent++;
    if (eval_byte(c, res)) pending_results.push_back(pinned ? pinned_res : res);
    @(negedge clk);
  endtask

  task automatic send_number(input longint unsigned v);
    logic [CHAR_W-1:0] digs[$];
    do begin
      digs.push_front(C_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 9) == 0) digs.push_front(C_ZERO);
    foreach (digs[i]) send_byte(digs[i]);
  endtask

  function automatic longint unsigned pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 99);
    if (sel < 7) return longint'($urandom);
    if (sel == 7) return 64'hFFFF_FFFF;
    if (sel == 8) return 64'd0;
    return {32'($urandom_range(0, 32'h7FFF_FFFF)), 32'($urandom)};
  endfunction

  task automatic send_expr();
    int                kind;
    logic [CHAR_W-1:0] op;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      // noise
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) send_byte(C_SPACE);
      if (kind != 2) send_number(pick_operand());
      if (kind != 3) begin
        repeat ($urandom_range(0, 2)) send_byte(C_SPACE);
        case ($urandom_range(0, 9))
          0, 1:    op = C_PLUS;
          2, 3:    op = C_MINUS;
          4, 5:    op = C_STAR;
          6, 7, 8: op = C_SLASH;
          default: op = 8'($urandom_range(1, 255));
        endcase
        send_byte(op);
        repeat ($urandom_range(0, 2)) send_byte(C_SPACE);
        if (kind != 4) begin
          if (op == C_SLASH && $urandom_range(0, 4) == 0) send_number(0);
          else send_number(pick_operand());
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
      end
    end
    send_byte(C_NUL);
  endtask

  task automatic drain();
    char_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random backpressure plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        res_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        res_ch.ready  = 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        res_ch.ready = 1'b1;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    calc_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.status == ST_DIVZERO) divzero_seen++;
      if (res_ch.status == ST_BADOP) badop_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: value %0h status %0d",
               res_ch.value, res_ch.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.value !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, res_ch.value);
          errors++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          errors++;
        end
      end
    end
  end

  initial begin
    calc_res_t pin;
    rst_n           = 1'b0;
    char_ch.valid   = 1'b0;
    char_ch.char_in = C_NUL;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      pin.value  = dir_tab[i].value;
      pin.status = dir_tab[i].status;
      send_byte(dir_tab[i].ch, dir_tab[i].pinned, pin);
    end
    drain();

    while (bytes_sent < N_BYTES) begin
      if (!hold_done && bytes_sent >= 300) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
        repeat (5) send_expr();
      end else if (!pause_done && bytes_sent >= 600) begin
        pause_done = 1'b1;
        send_expr();
        drain();
      end
      if (bytes_sent >= QUIET_FROM) gaps_on = 1'b0;
      send_expr();
    end
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d expression bytes; checked %0d results (%0d divide-by-zero, %0d bad-op).",
             bytes_sent, results_seen, divzero_seen, badop_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
